@@ hdl/assert_macros.svh @@
// Assertion macros shared by the line command parser RTL.
// Depends on nothing; defining NO_ASSERTIONS turns every use into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

@@ hdl/lcp_pkg.sv @@
// Types and character constants of the line command parser.
// Used by every module of the block; depends on nothing.
package lcp_pkg;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_7     = 8'h37;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_LZ    = 8'h7A;

   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   typedef enum logic [3:0] {
      PH_LEAD,
      PH_LETTER,
      PH_NUM_WS,
      PH_SIGN,
      PH_ZERO,
      PH_X,
      PH_DIGITS,
      PH_TRAIL,
      PH_ERR_EARLY,
      PH_ERR_LATE
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_OCT,
      RADIX_HEX
   } radix_type;

   typedef struct packed {
      logic        digit_ok;
      logic [31:0] mag;
      logic        ovf;
   } acc_res_type;

   typedef struct packed {
      logic        syntax_ok;
      logic        is_set;
      logic [7:0]  var_letter;
      logic [31:0] value;
   } result_type;

endpackage

@@ hdl/line_command_parser.sv @@
// Top level of the line command parser: input register, parser, result register.
// Depends on lcp_pkg, lcp_parser and assert_macros.svh.
//
//   chan | dir | handshake            | payload
//   req  | in  | req_valid, req_stall | req_rx_byte
//   rsp  | out | rsp_valid, rsp_stall | rsp_syntax_ok, rsp_is_set, rsp_var_letter, rsp_value
//
// One word is taken per cycle while req is not stalled; a byte is parsed when it
// advances out of the input register. A newline's result and rsp_valid are
// registered at the edge that parses it. Only a newline waits for the
// result register: while a result is stalled, bytes keep flowing until the next
// newline reaches the input register, which then stalls req. Reset is synchronous
// and brings the parser to the start of an empty line with cleared held values.
`include "assert_macros.svh"

module line_command_parser
   import lcp_pkg::*;
#(
   parameter int LINE_LENGTH = 32
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_syntax_ok,
   output logic              rsp_is_set,
   output logic [7:0]        rsp_var_letter,
   output logic signed [31:0] rsp_value
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type line_res;
   logic       take_in;
   logic       advance;
   logic       emit;

   assign advance   = in_valid_ff && (in_byte_ff != CH_NL || !rsp_valid_ff || !rsp_stall);
   assign emit      = advance && in_byte_ff == CH_NL;
   assign req_stall = in_valid_ff && !advance;
   assign take_in   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = take_in || (in_valid_ff && !advance);
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   lcp_parser #(
      .LINE_LENGTH (LINE_LENGTH)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .ch    (in_byte_ff),
      .res   (line_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) in_byte_ff <= req_rx_byte;
      if (emit) rsp_ff <= line_res;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_syntax_ok  = rsp_ff.syntax_ok;
   assign rsp_is_set     = rsp_ff.is_set;
   assign rsp_var_letter = rsp_ff.var_letter;
   assign rsp_value      = rsp_ff.value;

   `ASSERT_AT(a_rsp_from_newline, clock, reset, $rose(rsp_valid_ff) |-> $past(emit))
   `ASSERT_AT(a_held_byte_kept, clock, reset, req_stall |=> in_valid_ff && $stable(in_byte_ff))
   `ASSERT_NEVER(a_no_result_overwrite, clock, reset, emit && rsp_valid_ff && rsp_stall)

endmodule

@@ hdl/lcp_num_acc.sv @@
// Digit decoder and magnitude accumulator with unsigned 32-bit saturation.
// Depends on lcp_pkg.
module lcp_num_acc
   import lcp_pkg::*;
(
   input  logic [7:0]  ch,
   input  radix_type   radix,
   input  logic [31:0] mag,
   input  logic        ovf,
   output acc_res_type res
);

   logic        dig_valid;
   logic [4:0]  dig;
   logic        in_base;
   logic [35:0] prod;
   logic [35:0] sum;

   always_comb begin
      dig_valid = 1'b1;
      dig       = '0;
      if (ch >= CH_0 && ch <= CH_9) begin
         dig = 5'(ch - CH_0);
      end else if (ch >= CH_LA && ch <= CH_LF) begin
         dig = 5'(ch - CH_LA) + 5'd10;
      end else if (ch >= CH_UA && ch <= CH_UF) begin
         dig = 5'(ch - CH_UA) + 5'd10;
      end else begin
         dig_valid = 1'b0;
      end
   end

   // Multiplying by the base is a shift or a sum of two shifts.
   always_comb begin
      unique case (radix)
         RADIX_HEX: begin
            in_base = 1'b1;
            prod    = {mag, 4'b0000};
         end
         RADIX_OCT: begin
            in_base = (dig < 5'd8);
            prod    = {1'b0, mag, 3'b000};
         end
         default: begin
            in_base = (dig < 5'd10);
            prod    = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
         end
      endcase
   end

   assign sum = prod + {31'd0, dig};

   always_comb begin
      res.digit_ok = dig_valid && in_base;
      if (sum[35:32] != 4'd0) begin
         res.mag = '1;
         res.ovf = 1'b1;
      end else begin
         res.mag = sum[31:0];
         res.ovf = ovf;
      end
   end

endmodule

@@ hdl/lcp_parser.sv @@
// Line parser: phase state machine, number state and the held command.
// Depends on lcp_pkg and lcp_num_acc.
module lcp_parser
   import lcp_pkg::*;
#(
   parameter int LINE_LENGTH = 32
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] ch,
   output result_type res
);

   localparam int CountWidth = $clog2(LINE_LENGTH + 1);

   typedef struct packed {
      logic      load_letter;
      logic      mark_set;
      logic      mark_blank;
      logic      load_sign;
      logic      take;
      logic      load_radix;
      radix_type radix;
   } act_type;

   logic [CountWidth-1:0] count_ff, count_in;
   phase_type             phase_ff, phase_in, phase_nxt;
   logic                  ended_ff, ended_in;
   logic                  neg_ff, neg_in;
   radix_type             radix_ff, radix_in, radix_eff;
   logic [31:0]           mag_ff, mag_in;
   logic                  ovf_ff, ovf_in;
   logic                  blank_ff, blank_in;
   logic [7:0]            letter_ff, letter_in;
   logic [31:0]           value_ff, value_in;
   logic                  set_ff, set_in;
   logic                  ok_ff, ok_in;

   act_type     act;
   acc_res_type acc;
   logic        is_letter;
   logic        is_blank;
   logic        is_space;
   logic        is_nz_dec;
   logic        is_oct;
   logic [31:0] conv;
   logic        line_ok;

   assign is_space  = (ch == CH_SPACE);
   assign is_letter = (ch >= CH_LA && ch <= CH_LZ) || (ch >= CH_UA && ch <= CH_UZ);
   assign is_blank  = is_space || ch == CH_TAB || ch == CH_VT || ch == CH_FF || ch == CH_CR;
   assign is_nz_dec = (ch >= CH_1 && ch <= CH_9);
   assign is_oct    = (ch >= CH_0 && ch <= CH_7);

   // A zero that is followed by an x switches to hex; by an octal digit, to octal.
   always_comb begin
      case (phase_ff)
         PH_X:    radix_eff = RADIX_HEX;
         PH_ZERO: radix_eff = RADIX_OCT;
         default: radix_eff = radix_ff;
      endcase
   end

   lcp_num_acc u_acc (
      .ch    (ch),
      .radix (radix_eff),
      .mag   (mag_ff),
      .ovf   (ovf_ff),
      .res   (acc)
   );

   // Next phase for one content byte.
   always_comb begin
      phase_nxt = phase_ff;
      unique case (phase_ff) inside
         PH_LEAD: begin
            if (!is_space) phase_nxt = is_letter ? PH_LETTER : PH_ERR_EARLY;
         end
         PH_LETTER: begin
            if (!is_space) phase_nxt = (ch == CH_EQ) ? PH_NUM_WS : PH_ERR_LATE;
         end
         PH_NUM_WS: begin
            if (is_blank) phase_nxt = PH_NUM_WS;
            else if (ch == CH_PLUS || ch == CH_MINUS) phase_nxt = PH_SIGN;
            else if (ch == CH_0) phase_nxt = PH_ZERO;
            else if (is_nz_dec) phase_nxt = PH_DIGITS;
            else phase_nxt = PH_ERR_LATE;
         end
         PH_SIGN: begin
            if (ch == CH_0) phase_nxt = PH_ZERO;
            else if (is_nz_dec) phase_nxt = PH_DIGITS;
            else phase_nxt = PH_ERR_LATE;
         end
         PH_ZERO: begin
            if (ch == CH_LX || ch == CH_UX) phase_nxt = PH_X;
            else if (is_oct) phase_nxt = PH_DIGITS;
            else if (is_space) phase_nxt = PH_TRAIL;
            else phase_nxt = PH_ERR_LATE;
         end
         PH_X: begin
            phase_nxt = acc.digit_ok ? PH_DIGITS : PH_ERR_LATE;
         end
         PH_DIGITS: begin
            if (is_space) phase_nxt = PH_TRAIL;
            else if (!acc.digit_ok) phase_nxt = PH_ERR_LATE;
         end
         PH_TRAIL: begin
            if (!is_space) phase_nxt = PH_ERR_LATE;
         end
         PH_ERR_EARLY,
         PH_ERR_LATE: phase_nxt = phase_ff;
         default: phase_nxt = PH_ERR_LATE;
      endcase
   end

   // Side effects of one content byte on the number and the held command.
   always_comb begin
      act = '0;
      act.radix = RADIX_DEC;
      unique case (phase_ff)
         PH_LEAD: begin
            act.load_letter = !is_space && is_letter;
         end
         PH_LETTER: begin
            act.mark_set = (ch == CH_EQ);
         end
         PH_NUM_WS: begin
            act.mark_blank = is_blank && !is_space;
            act.load_sign  = !is_blank && (ch == CH_PLUS || ch == CH_MINUS);
            act.take       = is_nz_dec;
         end
         PH_SIGN: begin
            act.take = is_nz_dec;
         end
         PH_ZERO: begin
            act.take       = is_oct;
            act.load_radix = is_oct;
            act.radix      = RADIX_OCT;
         end
         PH_X: begin
            act.take       = 1'b1;
            act.load_radix = 1'b1;
            act.radix      = RADIX_HEX;
         end
         PH_DIGITS: begin
            act.take = !is_space;
         end
         default: ;
      endcase
   end

   // Signed saturation of the accumulated magnitude.
   always_comb begin
      if (neg_ff) begin
         conv = (ovf_ff || mag_ff[31]) ? SAT_NEG : (32'd0 - mag_ff);
      end else begin
         conv = (ovf_ff || mag_ff[31]) ? SAT_POS : mag_ff;
      end
   end

   always_comb begin
      case (phase_ff) inside
         PH_LETTER, PH_ZERO, PH_DIGITS, PH_TRAIL: line_ok = 1'b1;
         PH_NUM_WS: line_ok = !blank_ff;
         default:   line_ok = 1'b0;
      endcase
   end

   always_comb begin
      count_in  = count_ff;
      phase_in  = phase_ff;
      ended_in  = ended_ff;
      neg_in    = neg_ff;
      radix_in  = radix_ff;
      mag_in    = mag_ff;
      ovf_in    = ovf_ff;
      blank_in  = blank_ff;
      letter_in = letter_ff;
      value_in  = value_ff;
      set_in    = set_ff;
      ok_in     = ok_ff;
      if (step) begin
         if (ch == CH_NL) begin
            // An empty line keeps the previous result and repeats it.
            if (count_ff != '0) begin
               if (phase_ff != PH_LEAD && phase_ff != PH_ERR_EARLY && set_ff) begin
                  value_in = conv;
               end
               ok_in = line_ok;
            end
            count_in = '0;
            phase_in = PH_LEAD;
            ended_in = 1'b0;
            neg_in   = 1'b0;
            radix_in = RADIX_DEC;
            mag_in   = '0;
            ovf_in   = 1'b0;
            blank_in = 1'b0;
         end else if (count_ff < CountWidth'(LINE_LENGTH)) begin
            count_in = count_ff + CountWidth'(1);
            if (!ended_ff) begin
               if (ch == CH_NUL) begin
                  ended_in = 1'b1;
               end else begin
                  phase_in = phase_nxt;
                  if (act.load_letter) begin
                     letter_in = ch;
                     set_in    = 1'b0;
                  end
                  if (act.mark_set) set_in = 1'b1;
                  if (act.mark_blank) blank_in = 1'b1;
                  if (act.load_sign) neg_in = (ch == CH_MINUS);
                  if (act.load_radix) radix_in = act.radix;
                  if (act.take && acc.digit_ok) begin
                     mag_in = acc.mag;
                     ovf_in = acc.ovf;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         phase_ff  <= PH_LEAD;
         ended_ff  <= 1'b0;
         neg_ff    <= 1'b0;
         radix_ff  <= RADIX_DEC;
         mag_ff    <= '0;
         ovf_ff    <= 1'b0;
         blank_ff  <= 1'b0;
         letter_ff <= '0;
         value_ff  <= '0;
         set_ff    <= 1'b0;
         ok_ff     <= 1'b0;
      end else begin
         count_ff  <= count_in;
         phase_ff  <= phase_in;
         ended_ff  <= ended_in;
         neg_ff    <= neg_in;
         radix_ff  <= radix_in;
         mag_ff    <= mag_in;
         ovf_ff    <= ovf_in;
         blank_ff  <= blank_in;
         letter_ff <= letter_in;
         value_ff  <= value_in;
         set_ff    <= set_in;
         ok_ff     <= ok_in;
      end
   end

   // The result of a newline carries the values as updated by that newline.
   assign res.syntax_ok  = ok_in;
   assign res.is_set     = set_ff;
   assign res.var_letter = letter_ff;
   assign res.value      = value_in;

endmodule
